### rtl/core/bpf_program_preflight_checker_macros.svh
// assertion macros used by the preflight checker's check module
`ifndef BPF_PROGRAM_PREFLIGHT_CHECKER_MACROS_SVH
`define BPF_PROGRAM_PREFLIGHT_CHECKER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BPFPC_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define BPFPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bpfpc_pkg.sv
// types and constants of the bpf program preflight checker
package bpfpc_pkg;

   localparam int MAX_WORDS        = 65536;
   localparam int PROGRAM_BYTES_W  = 20;
   localparam int WORDS_W          = PROGRAM_BYTES_W - 3;
   localparam int WORD_IDX_W       = $clog2(MAX_WORDS);
   localparam int TGT_W            = WORDS_W + 1;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = PROGRAM_BYTES_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_BYTES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_OPTIONAL = 1'b1;

   localparam logic [7:0] OP_LDDW     = 8'h18;
   localparam logic [7:0] OP_CALL     = 8'h85;
   localparam logic [7:0] OP_EXIT     = 8'h95;
   localparam logic [2:0] CLASS_MASK  = 3'h7;
   localparam logic [2:0] CLASS_JMP   = 3'h5;
   localparam logic [3:0] REG_LIMIT   = 4'd11;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_LEN  = 3'd1,
      ST_BAD_REG  = 3'd2,
      ST_BAD_JUMP = 3'd3,
      ST_BAD_CALL = 3'd4,
      ST_NO_EXIT  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0]         opcode;
      logic [3:0]         dst_reg;
      logic [3:0]         src_reg;
      logic signed [15:0] jump_offset;
      logic [31:0]        immediate;
      logic               helper_known;
   } insn_type;

   typedef struct packed {
      logic [PROGRAM_BYTES_W-1:0] program_bytes;
      logic                       exit_optional;
   } cfg_type;

endpackage

### rtl/core/bpfpc_channels.sv
// valid/ready channel interfaces for instruction words and results
interface bpfpc_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         opcode;
   logic [3:0]         dst_reg;
   logic [3:0]         src_reg;
   logic signed [15:0] jump_offset;
   logic [31:0]        immediate;
   logic               helper_known;

   modport source (output valid, opcode, dst_reg, src_reg, jump_offset, immediate,
                   helper_known, input ready);
   modport sink (input valid, opcode, dst_reg, src_reg, jump_offset, immediate,
                 helper_known, output ready);
endinterface

interface bpfpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       final_res;

   modport source (output valid, status, final_res, input ready);
   modport sink (input valid, status, final_res, output ready);
endinterface

### rtl/core/bpfpc_in_stage.sv
// input register for instruction words
module bpfpc_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   bpfpc_req_if.sink            req,
   input  logic                 take,
   output logic                 insn_valid,
   output bpfpc_pkg::insn_type  insn
);

   logic                valid_ff, valid_in;
   bpfpc_pkg::insn_type insn_ff, insn_in;
   logic                load;

   // slot is free when empty or drained this cycle
   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      insn_in  = insn_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in             = 1'b1;
         insn_in.opcode       = req.opcode;
         insn_in.dst_reg      = req.dst_reg;
         insn_in.src_reg      = req.src_reg;
         insn_in.jump_offset  = req.jump_offset;
         insn_in.immediate    = req.immediate;
         insn_in.helper_known = req.helper_known;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      insn_ff <= insn_in;
   end

   assign insn_valid = valid_ff;
   assign insn       = insn_ff;

endmodule

### rtl/core/bpfpc_check.sv
// per-word checks, stream state and result register
`include "bpf_program_preflight_checker_macros.svh"

module bpfpc_check (
   input  logic                 clock,
   input  logic                 reset,
   input  bpfpc_pkg::cfg_type   cfg,
   input  logic                 insn_valid,
   input  bpfpc_pkg::insn_type  insn,
   output logic                 take,
   bpfpc_rsp_if.source          rsp
);

   logic [bpfpc_pkg::WORD_IDX_W-1:0] index_ff, index_in;
   logic                             skip_ff, skip_in;
   bpfpc_pkg::status_type            fault_ff, fault_in;
   logic                             out_valid_ff, out_valid_in;
   bpfpc_pkg::status_type            out_status_ff, out_status_in;
   logic                             out_final_ff, out_final_in;

   logic [bpfpc_pkg::WORDS_W-1:0]    words;
   logic                             len_bad;
   logic                             last;
   logic signed [bpfpc_pkg::TGT_W-1:0] idx_s, off_s, tgt;
   logic                             jump_bad;
   logic                             reg_bad;
   bpfpc_pkg::status_type            fault_new;

   assign take = insn_valid && (!out_valid_ff || rsp.ready);

   assign words   = cfg.program_bytes[bpfpc_pkg::PROGRAM_BYTES_W-1:3];
   assign len_bad = (cfg.program_bytes[2:0] != 3'd0) || (words == '0)
                    || (32'(words) > 32'(bpfpc_pkg::MAX_WORDS));
   // a shortened length makes any word at or past the end the last one
   assign last    = (bpfpc_pkg::WORDS_W'(index_ff) + bpfpc_pkg::WORDS_W'(1)) >= words;

   assign idx_s    = $signed({{(bpfpc_pkg::TGT_W - bpfpc_pkg::WORD_IDX_W){1'b0}}, index_ff});
   assign off_s    = bpfpc_pkg::TGT_W'(insn.jump_offset);
   assign tgt      = idx_s + off_s;
   assign jump_bad = (tgt < 0) || (tgt >= $signed({1'b0, words}));
   assign reg_bad  = (insn.dst_reg >= bpfpc_pkg::REG_LIMIT)
                     || (insn.src_reg >= bpfpc_pkg::REG_LIMIT);

   always_comb begin
      index_in      = index_ff;
      skip_in       = skip_ff;
      fault_in      = fault_ff;
      fault_new     = fault_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_final_in  = out_final_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in = 1'b1;
         if (len_bad) begin
            // stream state holds while the length is unusable
            out_status_in = bpfpc_pkg::ST_BAD_LEN;
            out_final_in  = 1'b1;
         end else begin
            if (fault_ff == bpfpc_pkg::ST_OK) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else if (reg_bad) begin
                  fault_new = bpfpc_pkg::ST_BAD_REG;
               end else if (insn.opcode == bpfpc_pkg::OP_LDDW) begin
                  skip_in = 1'b1;
               end else if (((insn.opcode[2:0] & bpfpc_pkg::CLASS_MASK)
                             == bpfpc_pkg::CLASS_JMP) && jump_bad) begin
                  fault_new = bpfpc_pkg::ST_BAD_JUMP;
               end else if ((insn.opcode == bpfpc_pkg::OP_CALL) && !insn.helper_known) begin
                  fault_new = bpfpc_pkg::ST_BAD_CALL;
               end
               if (last && (fault_new == bpfpc_pkg::ST_OK)
                   && (insn.opcode != bpfpc_pkg::OP_EXIT) && !cfg.exit_optional) begin
                  fault_new = bpfpc_pkg::ST_NO_EXIT;
               end
            end
            out_status_in = fault_new;
            out_final_in  = last;
            if (last) begin
               index_in = '0;
               skip_in  = 1'b0;
               fault_in = bpfpc_pkg::ST_OK;
            end else begin
               index_in = index_ff + bpfpc_pkg::WORD_IDX_W'(1);
               fault_in = fault_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         skip_ff      <= 1'b0;
         fault_ff     <= bpfpc_pkg::ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         skip_ff      <= skip_in;
         fault_ff     <= fault_in;
         out_valid_ff <= out_valid_in;
      end
      out_status_ff <= out_status_in;
      out_final_ff  <= out_final_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.final_res = out_final_ff;

   `BPFPC_ASSERT_NEXT(a_last_restarts, clock, reset, take && !len_bad && last,
      (index_ff == '0) && !skip_ff && (fault_ff == bpfpc_pkg::ST_OK),
      "stream state not cleared after last word")
   `BPFPC_ASSERT_NEXT(a_index_counts, clock, reset, take && !len_bad && !last,
      index_ff == bpfpc_pkg::WORD_IDX_W'($past(index_ff) + 1'b1),
      "word index did not advance")
   `BPFPC_ASSERT_NEXT(a_fault_sticks, clock, reset,
      take && !len_bad && !last && (fault_ff != bpfpc_pkg::ST_OK),
      fault_ff == $past(fault_ff), "latched fault changed mid-program")
   `BPFPC_ASSERT_NEXT(a_skip_once, clock, reset,
      take && !len_bad && !last && skip_ff && (fault_ff == bpfpc_pkg::ST_OK),
      !skip_ff, "wide load skipped more than one word")
   `BPFPC_ASSERT_NEXT(a_len_holds, clock, reset, take && len_bad,
      (index_ff == $past(index_ff)) && (fault_ff == $past(fault_ff)),
      "bad length disturbed stream state")

endmodule

### rtl/core/bpf_program_preflight_checker.sv
// top level of the bpf program preflight checker
// Checks an eBPF program one 8-byte instruction word per transfer and returns one result
// per word: the current status, and final_res on the program's last word where status is
// the verdict. A word is taken every cycle while results are drained; each result passes
// through the input register and then the result register around the check stage, where
// word index, wide-load skip and latched fault update together as each word is taken.
// Write program_bytes and exit_optional over the csr port only while no word is in flight;
// writes do not restart the stream, which restarts by itself after each last word.
module bpf_program_preflight_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   bpfpc_req_if.sink                            req_chan,
   bpfpc_rsp_if.source                          rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [bpfpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpfpc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   bpfpc_pkg::cfg_type  cfg_ff, cfg_in;
   logic                insn_valid;
   bpfpc_pkg::insn_type insn;
   logic                take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            bpfpc_pkg::CSR_PROGRAM_BYTES: begin
               cfg_in.program_bytes = csr_write_data[bpfpc_pkg::PROGRAM_BYTES_W-1:0];
            end
            bpfpc_pkg::CSR_EXIT_OPTIONAL: begin
               cfg_in.exit_optional = csr_write_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpfpc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .take       (take),
      .insn_valid (insn_valid),
      .insn       (insn)
   );

   bpfpc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .insn_valid (insn_valid),
      .insn       (insn),
      .take       (take),
      .rsp        (rsp_chan)
   );

endmodule
